// ===== hdl/battery_meter_display_encoder_top_macros.svh =====
// assertion helpers for the battery meter display encoder
`ifndef BATTERY_METER_DISPLAY_ENCODER_TOP_MACROS_SVH
`define BATTERY_METER_DISPLAY_ENCODER_TOP_MACROS_SVH
`ifndef SYNTH
`define BMDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmde assertion failed");
`define BMDE_ASSERT_DLY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("bmde assertion failed");
`else
`define BMDE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMDE_ASSERT_DLY2(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bmde_pkg.sv =====
`default_nettype none

package bmde_pkg;

    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned STAT_W  = 8;
    localparam int unsigned MV_W    = 15;
    localparam int unsigned WORD_W  = 29;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned SEG_W   = 7;
    localparam int unsigned BAR_W   = 5;

    localparam int unsigned SEG_RIGHT_LSB = 0;
    localparam int unsigned SEG_MID_LSB   = 7;
    localparam int unsigned SEG_LEFT_LSB  = 14;
    localparam int unsigned DP_BIT        = 21;
    localparam int unsigned VOLT_BIT      = 22;
    localparam int unsigned PCT_BIT       = 23;
    localparam int unsigned BAR_LSB       = 24;

    localparam logic [MV_W-1:0]  FULL_MV  = 15'd3800;
    localparam logic [MV_W-1:0]  EMPTY_MV = 15'd3000;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam int unsigned      PCT_SHIFT = 3;

    localparam int unsigned MODE_PCT_BIT = 0;

    typedef struct packed {
        logic [DIGIT_W-1:0] left;
        logic [DIGIT_W-1:0] mid;
        logic [DIGIT_W-1:0] right;
        logic               left_on;
        logic               mid_on;
    } disp_digits_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] p;
        case (d)
            4'd0:    p = 7'b0111111;
            4'd1:    p = 7'b0000011;
            4'd2:    p = 7'b1101101;
            4'd3:    p = 7'b1100111;
            4'd4:    p = 7'b1010011;
            4'd5:    p = 7'b1110110;
            4'd6:    p = 7'b1111110;
            4'd7:    p = 7'b0100011;
            4'd8:    p = 7'b1111111;
            4'd9:    p = 7'b1110111;
            default: p = '0;
        endcase
        return p;
    endfunction

    // filled from the top bit downward
    function automatic logic [BAR_W-1:0] level_bar(input logic [PCT_W-1:0] pct);
        logic [BAR_W-1:0] b;
        if (pct < 7'd5)
        begin
            b = 5'b00000;
        end
        else if (pct <= 7'd29)
        begin
            b = 5'b10000;
        end
        else if (pct <= 7'd49)
        begin
            b = 5'b11000;
        end
        else if (pct <= 7'd69)
        begin
            b = 5'b11100;
        end
        else if (pct <= 7'd89)
        begin
            b = 5'b11110;
        end
        else
        begin
            b = 5'b11111;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bmde_volt_digits.sv =====
`default_nettype none

module bmde_volt_digits (
    input  wire logic [bmde_pkg::MV_W-1:0] mv,
    output bmde_pkg::disp_digits_t         digits
);

    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam logic [31:0] DIV100_MUL  = 32'd5243;
    localparam logic [31:0] DIV1000_MUL = 32'd33555;

    logic [15:0] x;
    logic [31:0] p10;
    logic [31:0] p100;
    logic [31:0] p1000;
    logic [11:0] q1;
    logic [8:0]  q2;
    logic [5:0]  q3;
    logic [11:0] q2_x10;
    logic [8:0]  q3_x10;
    logic [11:0] d0_full;
    logic [8:0]  d1_full;
    logic [5:0]  d2_full;

    // round to tens, then take the three digits by reciprocal multiplies
    assign x     = {1'b0, mv} + 16'd5;
    assign p10   = {16'd0, x} * DIV10_MUL;
    assign p100  = {16'd0, x} * DIV100_MUL;
    assign p1000 = {16'd0, x} * DIV1000_MUL;

    assign q1 = p10[30:19];
    assign q2 = p100[27:19];
    assign q3 = p1000[30:25];

    assign q2_x10  = {q2, 3'b000} + {2'b00, q2, 1'b0};
    assign q3_x10  = {q3, 3'b000} + {2'b00, q3, 1'b0};
    assign d0_full = q1 - q2_x10;
    assign d1_full = q2 - q3_x10;

    always_comb
    begin
        if (q3 >= 6'd30)
        begin
            d2_full = q3 - 6'd30;
        end
        else if (q3 >= 6'd20)
        begin
            d2_full = q3 - 6'd20;
        end
        else if (q3 >= 6'd10)
        begin
            d2_full = q3 - 6'd10;
        end
        else
        begin
            d2_full = q3;
        end
    end

    always_comb
    begin
        digits.right   = d0_full[3:0];
        digits.mid     = d1_full[3:0];
        digits.left    = d2_full[3:0];
        digits.mid_on  = 1'b1;
        digits.left_on = (d2_full[3:0] != 4'd0);
    end

endmodule

`default_nettype wire

// ===== hdl/bmde_pct_digits.sv =====
`default_nettype none

module bmde_pct_digits (
    input  wire logic [bmde_pkg::MV_W-1:0]  mv,
    output logic      [bmde_pkg::PCT_W-1:0] pct,
    output bmde_pkg::disp_digits_t          digits
);

    localparam logic [14:0] DIV10_MUL = 15'd205;

    logic [bmde_pkg::MV_W-1:0] diff;
    logic [14:0]               prod;
    logic [3:0]                q;
    logic [6:0]                q_x10;
    logic [6:0]                d0_full;
    logic                      full;

    assign diff = mv - bmde_pkg::EMPTY_MV;

    always_comb
    begin
        if (mv >= bmde_pkg::FULL_MV)
        begin
            pct = bmde_pkg::PCT_FULL;
        end
        else if (mv <= bmde_pkg::EMPTY_MV)
        begin
            pct = '0;
        end
        else
        begin
            pct = diff[bmde_pkg::PCT_SHIFT +: bmde_pkg::PCT_W];
        end
    end

    // tens digit by reciprocal multiply
    assign prod    = {8'd0, pct} * DIV10_MUL;
    assign q       = prod[14:11];
    assign q_x10   = {q, 3'b000} + {2'b00, q, 1'b0};
    assign d0_full = pct - q_x10;
    assign full    = (pct == bmde_pkg::PCT_FULL);

    always_comb
    begin
        digits.right   = d0_full[3:0];
        digits.mid     = full ? 4'd0 : q;
        digits.left    = full ? 4'd1 : 4'd0;
        digits.left_on = full;
        digits.mid_on  = full || (q != 4'd0);
    end

endmodule

`default_nettype wire

// ===== hdl/battery_meter_display_encoder_top.sv =====
// battery meter display encoder
// input: pulse start with voltage_mv (signed millivolts) and status_bits;
// status_bits[0] high selects percent display, low selects volts as X.YZ
// busy is held low: a new word is taken on every cycle that start is high
// output: done strobes for one cycle with display_word, percent_level and
// sensor_error; the receiver takes the word in that cycle and cannot stall
// pipeline: an accepted word is held in one input register stage, then in one
// result register stage that drives done and the outputs; throughput is one
// word per cycle, set by the single pass of digit and level logic between
// the two
// a negative reading gives a zero display word, zero percent and
// sensor_error high
// reset: rst_n low clears the pipeline valid flags, so no done strobe comes
// out until a new word is started; words in flight at reset are dropped
`default_nettype none
`include "battery_meter_display_encoder_top_macros.svh"

module battery_meter_display_encoder_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [bmde_pkg::VOLT_W-1:0]   voltage_mv,
    input  wire logic        [bmde_pkg::STAT_W-1:0]   status_bits,
    output logic                                      done,
    output logic             [bmde_pkg::WORD_W-1:0]   display_word,
    output logic             [bmde_pkg::PCT_W-1:0]    percent_level,
    output logic                                      sensor_error
);

    logic                                    in_valid_reg;
    logic signed [bmde_pkg::VOLT_W-1:0]      volt_reg;
    logic                                    mode_reg;

    logic                                    done_reg;
    logic        [bmde_pkg::WORD_W-1:0]      word_reg;
    logic        [bmde_pkg::PCT_W-1:0]       pct_reg;
    logic                                    err_reg;

    logic        [bmde_pkg::WORD_W-1:0]      word_next;
    logic        [bmde_pkg::PCT_W-1:0]       pct_next;
    logic                                    err_next;

    logic        [bmde_pkg::MV_W-1:0]        mv;
    logic        [bmde_pkg::PCT_W-1:0]       pct;
    bmde_pkg::disp_digits_t                  volt_digits;
    bmde_pkg::disp_digits_t                  pct_digits;
    bmde_pkg::disp_digits_t                  sel_digits;
    logic                                    accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            volt_reg <= voltage_mv;
            mode_reg <= status_bits[bmde_pkg::MODE_PCT_BIT];
        end
        if (in_valid_reg)
        begin
            word_reg <= word_next;
            pct_reg  <= pct_next;
            err_reg  <= err_next;
        end
    end

    assign mv = volt_reg[bmde_pkg::MV_W-1:0];

    bmde_volt_digits u_volt_digits (
        .mv     (mv),
        .digits (volt_digits)
    );

    bmde_pct_digits u_pct_digits (
        .mv     (mv),
        .pct    (pct),
        .digits (pct_digits)
    );

    assign sel_digits = mode_reg ? pct_digits : volt_digits;
    assign err_next   = volt_reg[bmde_pkg::VOLT_W-1];

    always_comb
    begin
        word_next = '0;
        pct_next  = '0;
        if (!err_next)
        begin
            pct_next = pct;
            word_next[bmde_pkg::SEG_RIGHT_LSB +: bmde_pkg::SEG_W] =
                bmde_pkg::seg_pattern(sel_digits.right);
            if (sel_digits.mid_on)
            begin
                word_next[bmde_pkg::SEG_MID_LSB +: bmde_pkg::SEG_W] =
                    bmde_pkg::seg_pattern(sel_digits.mid);
            end
            if (sel_digits.left_on)
            begin
                word_next[bmde_pkg::SEG_LEFT_LSB +: bmde_pkg::SEG_W] =
                    bmde_pkg::seg_pattern(sel_digits.left);
            end
            word_next[bmde_pkg::DP_BIT]   = !mode_reg;
            word_next[bmde_pkg::VOLT_BIT] = !mode_reg;
            word_next[bmde_pkg::PCT_BIT]  = mode_reg;
            word_next[bmde_pkg::BAR_LSB +: bmde_pkg::BAR_W] = bmde_pkg::level_bar(pct);
        end
    end

    assign done          = done_reg;
    assign display_word  = word_reg;
    assign percent_level = pct_reg;
    assign sensor_error  = err_reg;

    `BMDE_ASSERT_DLY2(a_start_gives_done, clk, rst_n, accept, done)
    `BMDE_ASSERT_IMP(a_done_has_start, clk, rst_n, done, $past(accept, 2))
    `BMDE_ASSERT_IMP(a_error_blanks, clk, rst_n, done && sensor_error, (display_word == '0) && (percent_level == '0))
    `BMDE_ASSERT_IMP(a_one_mode_lit, clk, rst_n, done && !sensor_error, display_word[bmde_pkg::VOLT_BIT] != display_word[bmde_pkg::PCT_BIT])
    `BMDE_ASSERT_IMP(a_pct_in_range, clk, rst_n, done, percent_level <= bmde_pkg::PCT_FULL)

endmodule

`default_nettype wire
